// ===== rtl/tbrl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tbrl_pkg;

    localparam int STAT_WIDTH  = 32;
    localparam int TOKEN_W     = 16;
    localparam int TIME_W      = 32;
    localparam int PROD_W      = TOKEN_W + TIME_W;
    localparam int ADD_STEPS   = TOKEN_W;
    localparam int PER_STEPS   = TIME_W;
    localparam int CNT_W       = $clog2(PER_STEPS);
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 152;

    localparam logic [TOKEN_W-1:0] MAX_TOKENS_RST = 16'd10;
    localparam logic [TIME_W-1:0]  WINDOW_RST     = 32'd1000;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_ACQUIRE = 2'd1,
        MODE_CLEAR   = 2'd2
    } mode_t;

    typedef enum logic {
        REG_MAX_TOKENS = 1'b0,
        REG_WINDOW_MS  = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_ADD,
        ST_REFILL,
        ST_TAKE,
        ST_CHECK,
        ST_DIV_PER,
        ST_WAIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/token_bucket_rate_limiter.sv =====
// Each accepted beat walks the states: tick, clear and unused items go via ST_CHECK to ST_DONE,
// an acquire after a whole window via ST_TAKE and ST_CHECK, one that needs the refill division
// via ST_MUL, ST_DIV_ADD, ST_REFILL, ST_TAKE and ST_CHECK; an empty bucket adds the wait
// division (ST_DIV_PER, ST_WAIT). The shared restoring divider gives one quotient bit a cycle.
// One item at a time (s_tready only in ST_IDLE); ST_DONE holds while a result waits for m_tready.
// Reset (rst_n low, asynchronous): 10 tokens, window 1000 ms, elapsed and statistics cleared.
`timescale 1ns / 1ps
`default_nettype none

module token_bucket_rate_limiter
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [tbrl_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] ticks
    input  wire logic [1:0]                       s_tuser,   // [1:0] mode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] granted, [16:1] tokens_left, [48:17] wait_ms, [80:49] total_count,
    // [112:81] allowed_count, [144:113] denied_count, [151:145] zero
    output logic [tbrl_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_index,
    input  wire logic [31:0]                      cfg_data
);

    localparam int TW = tbrl_pkg::TOKEN_W;
    localparam int EW = tbrl_pkg::TIME_W;
    localparam int SW = tbrl_pkg::STAT_WIDTH;

    tbrl_pkg::state_t state_reg, state_next;

    logic [TW-1:0] max_tokens_reg;
    logic [EW-1:0] window_reg;
    logic [TW-1:0] tokens_reg, tokens_next;
    logic [EW-1:0] elapsed_reg, elapsed_next;
    logic [SW-1:0] attempts_reg, attempts_next;
    logic [SW-1:0] grants_reg, grants_next;
    logic [SW-1:0] denials_reg, denials_next;
    logic          granted_reg, granted_next;
    logic [EW-1:0] wait_reg, wait_next;

    // Shared restoring divider.
    logic [EW-1:0]                  rem_reg, rem_next;
    logic [EW-1:0]                  quo_reg, quo_next;
    logic [EW-1:0]                  den_reg, den_next;
    logic [tbrl_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    logic [tbrl_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                            out_valid_reg, out_valid_next;

    logic [EW:0]               rem_shift;
    logic                      quo_bit;
    logic [EW:0]               rem_diff;
    logic [EW-1:0]             rem_step;
    logic [EW-1:0]             quo_step;
    logic [tbrl_pkg::PROD_W-1:0] product;
    logic [EW:0]               elapsed_sum;
    logic [TW:0]               token_sum;

    assign rem_shift = {rem_reg, quo_reg[EW-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign quo_bit   = (rem_shift >= {1'b0, den_reg});
    assign rem_step  = quo_bit ? rem_diff[EW-1:0] : rem_shift[EW-1:0];
    assign quo_step  = {quo_reg[EW-2:0], quo_bit};

    assign product     = elapsed_reg * max_tokens_reg;
    assign elapsed_sum = {1'b0, elapsed_reg} + (EW+1)'(s_tdata[15:0]);
    assign token_sum   = {1'b0, tokens_reg} + {1'b0, quo_reg[TW-1:0]};

    assign s_tready  = (state_reg == tbrl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tokens_reg <= tbrl_pkg::MAX_TOKENS_RST;
            window_reg     <= tbrl_pkg::WINDOW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (tbrl_pkg::cfg_reg_t'(cfg_index))
                tbrl_pkg::REG_MAX_TOKENS: max_tokens_reg <= cfg_data[TW-1:0];
                tbrl_pkg::REG_WINDOW_MS:  window_reg     <= cfg_data[EW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tbrl_pkg::ST_IDLE;
            tokens_reg    <= tbrl_pkg::MAX_TOKENS_RST;
            elapsed_reg   <= '0;
            attempts_reg  <= '0;
            grants_reg    <= '0;
            denials_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tokens_reg    <= tokens_next;
            elapsed_reg   <= elapsed_next;
            attempts_reg  <= attempts_next;
            grants_reg    <= grants_next;
            denials_reg   <= denials_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        granted_reg  <= granted_next;
        wait_reg     <= wait_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_reg      <= den_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        tokens_next    = tokens_reg;
        elapsed_next   = elapsed_reg;
        attempts_next  = attempts_reg;
        grants_next    = grants_reg;
        denials_next   = denials_reg;
        granted_next   = granted_reg;
        wait_next      = wait_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tbrl_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    granted_next = 1'b0;
                    state_next   = tbrl_pkg::ST_CHECK;
                    case (tbrl_pkg::mode_t'(s_tuser))
                        tbrl_pkg::MODE_TICK:
                        begin
                            elapsed_next = elapsed_sum[EW] ? '1 : elapsed_sum[EW-1:0];
                        end
                        tbrl_pkg::MODE_ACQUIRE:
                        begin
                            attempts_next = attempts_reg + SW'(1);
                            if (elapsed_reg >= window_reg)
                            begin
                                tokens_next  = max_tokens_reg;
                                elapsed_next = '0;
                                state_next   = tbrl_pkg::ST_TAKE;
                            end
                            else
                            begin
                                state_next = tbrl_pkg::ST_MUL;
                            end
                        end
                        tbrl_pkg::MODE_CLEAR:
                        begin
                            attempts_next = '0;
                            grants_next   = '0;
                            denials_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end

            tbrl_pkg::ST_MUL:
            begin
                // Elapsed is below the window, so the upper part of the product is
                // already below the divisor and only the low token bits need steps.
                rem_next   = product[tbrl_pkg::PROD_W-1:TW];
                quo_next   = {product[TW-1:0], {(EW-TW){1'b0}}};
                den_next   = window_reg;
                cnt_next   = tbrl_pkg::CNT_W'(tbrl_pkg::ADD_STEPS - 1);
                state_next = tbrl_pkg::ST_DIV_ADD;
            end

            tbrl_pkg::ST_DIV_ADD:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - tbrl_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = tbrl_pkg::ST_REFILL;
                end
            end

            tbrl_pkg::ST_REFILL:
            begin
                if (quo_reg[TW-1:0] != '0)
                begin
                    tokens_next  = (token_sum < {1'b0, max_tokens_reg}) ? token_sum[TW-1:0]
                                                                        : max_tokens_reg;
                    elapsed_next = '0;
                end
                state_next = tbrl_pkg::ST_TAKE;
            end

            tbrl_pkg::ST_TAKE:
            begin
                if (tokens_reg != '0)
                begin
                    tokens_next  = tokens_reg - TW'(1);
                    grants_next  = grants_reg + SW'(1);
                    granted_next = 1'b1;
                end
                else
                begin
                    denials_next = denials_reg + SW'(1);
                end
                state_next = tbrl_pkg::ST_CHECK;
            end

            tbrl_pkg::ST_CHECK:
            begin
                if (tokens_reg != '0)
                begin
                    wait_next  = '0;
                    state_next = tbrl_pkg::ST_DONE;
                end
                else
                begin
                    // A zero capacity divides to all ones, which is the intended period.
                    rem_next   = '0;
                    quo_next   = window_reg;
                    den_next   = EW'(max_tokens_reg);
                    cnt_next   = tbrl_pkg::CNT_W'(tbrl_pkg::PER_STEPS - 1);
                    state_next = tbrl_pkg::ST_DIV_PER;
                end
            end

            tbrl_pkg::ST_DIV_PER:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - tbrl_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = tbrl_pkg::ST_WAIT;
                end
            end

            tbrl_pkg::ST_WAIT:
            begin
                wait_next  = (elapsed_reg < quo_reg) ? (quo_reg - elapsed_reg) : '0;
                state_next = tbrl_pkg::ST_DONE;
            end

            tbrl_pkg::ST_DONE:
            begin
                // The previous result must have left before this one is loaded.
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {7'd0,
                                      32'(denials_reg),
                                      32'(grants_reg),
                                      32'(attempts_reg),
                                      wait_reg,
                                      tokens_reg,
                                      granted_reg};
                    out_valid_next = 1'b1;
                    state_next     = tbrl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tbrl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== verif/tbrl_checker.sv =====
`timescale 1ns / 1ps

module tbrl_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [tbrl_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] ticks
    input  logic [1:0]                       s_tuser,   // [1:0] mode
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] granted, [16:1] tokens_left, [48:17] wait_ms, [80:49] total_count,
    // [112:81] allowed_count, [144:113] denied_count, [151:145] zero
    input  logic [tbrl_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [31:0]                      cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               beats_in,
    output int                               beats_out,
    output int                               grants_seen,
    output int                               denials_seen
);

    typedef struct packed {
        logic        granted;
        logic [15:0] tokens_left;
        logic [31:0] wait_ms;
        logic [31:0] total_count;
        logic [31:0] allowed_count;
        logic [31:0] denied_count;
    } limiter_report_t;

    // Shadow copy of the bucket, its registers and the statistics.
    logic [tbrl_pkg::TOKEN_W-1:0]    cap;
    logic [tbrl_pkg::TIME_W-1:0]     window_len;
    logic [tbrl_pkg::TOKEN_W-1:0]    bkt;
    logic [tbrl_pkg::TIME_W-1:0]     elapsed;
    logic [tbrl_pkg::STAT_WIDTH-1:0] n_attempts;
    logic [tbrl_pkg::STAT_WIDTH-1:0] n_grants;
    logic [tbrl_pkg::STAT_WIDTH-1:0] n_denials;

    limiter_report_t report_q[$];

    function automatic limiter_report_t apply_item(input logic [1:0] mode,
                                                   input logic [15:0] ticks);
        limiter_report_t r;
        logic [32:0]     esum;
        logic [63:0]     share;
        logic [63:0]     level;
        logic [31:0]     per;
        r = '0;
        case (mode)
            tbrl_pkg::MODE_TICK:
            begin
                esum = {1'b0, elapsed} + {17'b0, ticks};
                elapsed = esum[32] ? '1 : esum[31:0];
            end
            tbrl_pkg::MODE_ACQUIRE:
            begin
                if (elapsed >= window_len)
                begin
                    bkt = cap;
                    elapsed = '0;
                end
                else
                begin
                    // The window is strictly larger than elapsed here, so never zero.
                    share = (64'(elapsed) * 64'(cap)) / 64'(window_len);
                    if (share != 64'd0)
                    begin
                        level = 64'(bkt) + share;
                        bkt = (level < 64'(cap)) ? level[15:0] : cap;
                        elapsed = '0;
                    end
                end
                n_attempts = n_attempts + 1'b1;
                if (bkt != '0)
                begin
                    bkt = bkt - 1'b1;
                    n_grants = n_grants + 1'b1;
                    r.granted = 1'b1;
                    grants_seen++;
                end
                else
                begin
                    n_denials = n_denials + 1'b1;
                    denials_seen++;
                end
            end
            tbrl_pkg::MODE_CLEAR:
            begin
                n_attempts = '0;
                n_grants = '0;
                n_denials = '0;
            end
            default:
            begin
            end
        endcase
        r.tokens_left = bkt;
        if (bkt != '0)
            r.wait_ms = '0;
        else
        begin
            per = (cap == '0) ? '1 : window_len / 32'(cap);
            r.wait_ms = (elapsed >= per) ? 32'd0 : per - elapsed;
        end
        r.total_count = 32'(n_attempts);
        r.allowed_count = 32'(n_grants);
        r.denied_count = 32'(n_denials);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        limiter_report_t want;
        if (!rst_n)
        begin
            cap = tbrl_pkg::MAX_TOKENS_RST;
            window_len = tbrl_pkg::WINDOW_RST;
            bkt = tbrl_pkg::MAX_TOKENS_RST;
            elapsed = '0;
            n_attempts = '0;
            n_grants = '0;
            n_denials = '0;
            report_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tbrl_pkg::REG_MAX_TOKENS)
                    cap = cfg_data[15:0];
                else
                    window_len = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                report_q.push_back(apply_item(s_tuser, s_tdata[15:0]));
                beats_in++;
            end
            if (m_tvalid && m_tready)
            begin
                beats_out++;
                if (report_q.size() == 0)
                begin
                    $error("result beat arrived with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("granted", 32'(want.granted), 32'(m_tdata[0]));
                    check_field("tokens_left", 32'(want.tokens_left), 32'(m_tdata[16:1]));
                    check_field("wait_ms", want.wait_ms, m_tdata[48:17]);
                    check_field("total_count", want.total_count, m_tdata[80:49]);
                    check_field("allowed_count", want.allowed_count, m_tdata[112:81]);
                    check_field("denied_count", want.denied_count, m_tdata[144:113]);
                    check_field("padding", 32'd0, 32'(m_tdata[151:145]));
                end
            end
            pending = report_q.size();
        end
    end

endmodule

// ===== verif/tb_token_bucket_rate_limiter.sv =====
`timescale 1ns / 1ps

module tb_token_bucket_rate_limiter;

    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         RX_HOLD_CYCLES  = 200;
    localparam int         ITEMS_PER_PHASE = 58;
    localparam int         N_PHASES        = 9;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [tbrl_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tbrl_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic                            cfg_index;
    logic [31:0]                     cfg_data;

    int fail_count;
    int pending;
    int beats_in;
    int beats_out;
    int grants_seen;
    int denials_seen;

    int send_idle_pct;
    int recv_idle_pct;
    bit rx_hold_req;
    int settings_used;

    token_bucket_rate_limiter u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tbrl_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .beats_in     (beats_in),
        .beats_out    (beats_out),
        .grants_seen  (grants_seen),
        .denials_seen (denials_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Run timed out with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic offer_request(input logic [1:0] mode, input logic [15:0] ticks);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = mode;
        s_tdata = ticks;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input tbrl_pkg::cfg_reg_t idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_regime(input int sel);
        case (sel % 3)
            0:
            begin
                send_idle_pct = 33;
                recv_idle_pct = 67;
            end
            1:
            begin
                send_idle_pct = 67;
                recv_idle_pct = 33;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    initial
    begin
        logic [15:0] cap_list [N_PHASES];
        logic [31:0] win_list [N_PHASES];
        int          r;
        logic [1:0]  md;
        logic [15:0] tk;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = tbrl_pkg::MODE_TICK;
        cfg_valid = 1'b0;
        cfg_index = tbrl_pkg::REG_MAX_TOKENS;
        cfg_data = '0;
        rx_hold_req = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        settings_used = 1;

        // Phase 0 keeps the reset setting; the others cover the register extremes,
        // a zero capacity and a zero window, then random settings.
        cap_list[0] = tbrl_pkg::MAX_TOKENS_RST;  win_list[0] = tbrl_pkg::WINDOW_RST;
        cap_list[1] = 16'd1;           win_list[1] = 32'd1;
        cap_list[2] = 16'hFFFF;        win_list[2] = 32'hFFFF_FFFF;
        cap_list[3] = 16'd0;           win_list[3] = 32'd500;
        cap_list[4] = 16'd5;           win_list[4] = 32'd0;
        cap_list[5] = 16'd3;           win_list[5] = 32'd100;
        cap_list[6] = 16'hFFFF;        win_list[6] = 32'd1;
        cap_list[7] = 16'($urandom_range(1, 64));
        win_list[7] = $urandom_range(50, 5000);
        cap_list[8] = 16'($urandom);
        win_list[8] = $urandom;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset setting: drain the bucket, partial and whole
        // refills, the unused mode and a statistics clear.
        set_regime(0);
        offer_request(tbrl_pkg::MODE_ACQUIRE, 16'd0);
        offer_request(tbrl_pkg::MODE_TICK, 16'd0);
        offer_request(tbrl_pkg::MODE_TICK, 16'hFFFF);
        repeat (10) offer_request(tbrl_pkg::MODE_ACQUIRE, 16'hFFFF);
        offer_request(tbrl_pkg::MODE_ACQUIRE, 16'd0);
        offer_request(tbrl_pkg::MODE_TICK, 16'd50);
        offer_request(tbrl_pkg::MODE_ACQUIRE, 16'd0);
        offer_request(tbrl_pkg::MODE_TICK, 16'd50);
        offer_request(tbrl_pkg::MODE_ACQUIRE, 16'd0);
        offer_request(MODE_UNUSED, 16'hFFFF);
        offer_request(tbrl_pkg::MODE_CLEAR, 16'hFFFF);
        offer_request(MODE_UNUSED, 16'd0);
        offer_request(tbrl_pkg::MODE_TICK, 16'hAAAA);
        offer_request(tbrl_pkg::MODE_TICK, 16'h5555);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                s_tvalid = 1'b0;
                wait_drained();
                write_reg(tbrl_pkg::REG_MAX_TOKENS, {16'($urandom), cap_list[ph]});
                write_reg(tbrl_pkg::REG_WINDOW_MS, win_list[ph]);
                settings_used++;
            end
            set_regime(ph);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (ph == 2 && i == 20)
                    rx_hold_req = 1'b1;
                if (ph == 5 && i == 30)
                    wait_drained();
                r = $urandom_range(99);
                if (r < 50)
                    md = tbrl_pkg::MODE_ACQUIRE;
                else if (r < 88)
                    md = tbrl_pkg::MODE_TICK;
                else if (r < 94)
                    md = tbrl_pkg::MODE_CLEAR;
                else
                    md = MODE_UNUSED;
                r = $urandom_range(99);
                if (r < 50)
                    tk = 16'($urandom_range(0, 63));
                else if (r < 85)
                    tk = 16'($urandom_range(0, 2047));
                else
                    tk = 16'($urandom);
                offer_request(md, tk);
            end
        end

        // One token per longest window: partial refills come to nothing, so the
        // elapsed count keeps growing and an empty bucket reports a long wait.
        wait_drained();
        write_reg(tbrl_pkg::REG_MAX_TOKENS, 32'd1);
        write_reg(tbrl_pkg::REG_WINDOW_MS, 32'hFFFF_FFFF);
        settings_used++;
        set_regime(2);
        offer_request(tbrl_pkg::MODE_ACQUIRE, 16'd0);
        offer_request(tbrl_pkg::MODE_ACQUIRE, 16'd0);
        repeat (3) offer_request(tbrl_pkg::MODE_TICK, 16'hFFFF);
        offer_request(MODE_UNUSED, 16'd0);
        offer_request(tbrl_pkg::MODE_ACQUIRE, 16'd0);
        offer_request(tbrl_pkg::MODE_ACQUIRE, 16'd0);
        offer_request(tbrl_pkg::MODE_TICK, 16'd7);
        offer_request(tbrl_pkg::MODE_ACQUIRE, 16'd0);

        wait_drained();
        repeat (60) @(negedge clk);

        $display("Run covered %0d request beats and %0d result beats over %0d register settings,",
                 beats_in, beats_out, settings_used);
        $display("with %0d grants, %0d denials, a long output stall and a full drain pause.",
                 grants_seen, denials_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
